// File: rtl/cdad_pkg.sv
// ----------------------------------------------------------------------------
// cdad_pkg: shared types, constants and helpers for the date adder
// Field widths, month table and the leap year rule used by the channels
// and by the sequencer of calendar_date_add_days.
// ----------------------------------------------------------------------------
package cdad_pkg;

    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 16;

    // Remaining offset carries one extra bit for the sign of the running sum.
    localparam int REM_W = OFFSET_W + 1;

    // Year split into year / 100 and year % 100.
    localparam int CENT_W = 8;
    localparam int YMOD_W = 7;

    localparam logic [YEAR_W-1:0]  YEAR_MAX = YEAR_W'(16383);
    localparam logic [YMOD_W-1:0]  YMOD_TOP = YMOD_W'(99);
    localparam logic [7:0]         HUNDRED  = 8'd100;

    // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for every 14-bit y.
    localparam logic [12:0]        DIV100_MUL   = 13'd5243;
    localparam int                 DIV100_SHIFT = 19;

    localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;

    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [YEAR_W-1:0]  year_t;

    // Length of a month (1..12) given whether its year is a leap year.
    function automatic day_t month_len(input month_t m, input logic leap);
        day_t len;
        len = 5'd31;
        case (m) inside
            [JAN:DEC]: len = MONTH_LEN[4'(m - JAN)];
            default:   len = 5'd31;
        endcase
        if (m == FEB && leap)
        begin
            len = FEB_LEAP_LEN;
        end
        return len;
    endfunction

    // Gregorian rule from the year split by 100: a century year is a leap
    // year only when its century count is a multiple of four.
    function automatic logic is_leap(input logic [1:0] year_lo,
                                     input logic [YMOD_W-1:0] ymod,
                                     input logic [1:0] cent_lo);
        logic leap;
        if (ymod != '0)
        begin
            leap = (year_lo == 2'd0);
        end
        else
        begin
            leap = (cent_lo == 2'd0);
        end
        return leap;
    endfunction

endpackage

// File: rtl/cdad_in_if.sv
// ----------------------------------------------------------------------------
// cdad_in_if: input channel of the date adder
// Carries a date and a signed day offset under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdad_in_if
    import cdad_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [MONTH_W-1:0]     in_month;
    logic [DAY_W-1:0]       in_day;
    logic [YEAR_W-1:0]      in_year;
    logic signed [OFFSET_W-1:0] day_offset;

    modport source (
        output valid, in_month, in_day, in_year, day_offset,
        input  ready
    );

    modport sink (
        input  valid, in_month, in_day, in_year, day_offset,
        output ready
    );
endinterface

// File: rtl/cdad_out_if.sv
// ----------------------------------------------------------------------------
// cdad_out_if: result channel of the date adder
// Carries the moved date and its status flags under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdad_out_if
    import cdad_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [YEAR_W-1:0]  out_year;
    logic               input_corrected;
    logic               range_error;

    modport source (
        output valid, out_month, out_day, out_year, input_corrected, range_error,
        input  ready
    );

    modport sink (
        input  valid, out_month, out_day, out_year, input_corrected, range_error,
        output ready
    );
endinterface

// File: rtl/calendar_date_add_days.sv
// Timing: after a request is taken, S_DIV, S_REM and S_CLAMP set up the
// walk and S_RUN steps across month boundaries, then the item waits in the
// output register until taken. Throughput: one item at a time; the month
// stepping loop sets the rate.
// Reset: asynchronous, active low; the block comes up idle and ready.
// ----------------------------------------------------------------------------
// calendar_date_add_days: Gregorian date plus signed day offset
// Clamps the input date, then walks the calendar a month per cycle until the
// remaining offset fits inside the current month or the year range runs out.
// ----------------------------------------------------------------------------
module calendar_date_add_days
    import cdad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cdad_in_if.sink     req,
    cdad_out_if.source  rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_REM   = 3'd2;
    localparam logic [2:0] S_CLAMP = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]               state_reg, state_next;
    month_t                   m_reg, m_next;
    day_t                     d_reg, d_next;
    year_t                    y_reg, y_next;
    logic signed [REM_W-1:0]  r_reg, r_next;
    logic [CENT_W-1:0]        cent_reg, cent_next;
    logic [YMOD_W-1:0]        ymod_reg, ymod_next;
    logic                     corr_reg, corr_next;
    logic                     err_reg, err_next;
    month_t                   sm_reg, sm_next;
    day_t                     sd_reg, sd_next;
    year_t                    sy_reg, sy_next;

    logic [YEAR_W+12:0]       div_prod;
    logic [YEAR_W-1:0]        cent_x100;
    logic                     leap;
    day_t                     cur_len;
    day_t                     room;
    logic signed [REM_W-1:0]  fwd_rest;
    logic signed [REM_W-1:0]  bwd_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        d_reg    <= d_next;
        y_reg    <= y_next;
        r_reg    <= r_next;
        cent_reg <= cent_next;
        ymod_reg <= ymod_next;
        corr_reg <= corr_next;
        err_reg  <= err_next;
        sm_reg   <= sm_next;
        sd_reg   <= sd_next;
        sy_reg   <= sy_next;
    end

    assign div_prod  = y_reg * DIV100_MUL;
    assign cent_x100 = YEAR_W'(cent_reg) * YEAR_W'(HUNDRED);
    assign leap      = is_leap(y_reg[1:0], ymod_reg, cent_reg[1:0]);
    assign cur_len   = month_len(m_reg, leap);
    assign room      = cur_len - d_reg;
    assign fwd_rest  = r_reg - $signed({{(REM_W-DAY_W){1'b0}}, room})
                       - REM_W'(1);
    assign bwd_sum   = r_reg + $signed({{(REM_W-DAY_W){1'b0}}, d_reg});

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        y_next     = y_reg;
        r_next     = r_reg;
        cent_next  = cent_reg;
        ymod_next  = ymod_reg;
        corr_next  = corr_reg;
        err_next   = err_reg;
        sm_next    = sm_reg;
        sd_next    = sd_reg;
        sy_next    = sy_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    d_next    = req.in_day;
                    y_next    = req.in_year;
                    r_next    = REM_W'(req.day_offset);
                    err_next  = 1'b0;
                    corr_next = 1'b0;
                    m_next    = req.in_month;
                    if (req.in_month == '0)
                    begin
                        m_next    = JAN;
                        corr_next = 1'b1;
                    end
                    else if (req.in_month > DEC)
                    begin
                        m_next    = DEC;
                        corr_next = 1'b1;
                    end
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                cent_next  = div_prod[DIV100_SHIFT +: CENT_W];
                state_next = S_REM;
            end

            S_REM:
            begin
                ymod_next  = YMOD_W'(y_reg - cent_x100);
                state_next = S_CLAMP;
            end

            S_CLAMP:
            begin
                if (d_reg == '0)
                begin
                    d_next    = DAY_W'(1);
                    corr_next = 1'b1;
                end
                else if (d_reg > cur_len)
                begin
                    d_next    = cur_len;
                    corr_next = 1'b1;
                end
                sm_next    = m_reg;
                sd_next    = d_next;
                sy_next    = y_reg;
                state_next = S_RUN;
            end

            S_RUN:
            begin
                if (r_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (!r_reg[REM_W-1])
                begin
                    if (r_reg <= $signed({{(REM_W-DAY_W){1'b0}}, room}))
                    begin
                        d_next     = d_reg + r_reg[DAY_W-1:0];
                        r_next     = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Spend the rest of this month and land on the 1st.
                        r_next = fwd_rest;
                        d_next = DAY_W'(1);
                        if (m_reg == DEC)
                        begin
                            if (y_reg == YEAR_MAX)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                m_next = JAN;
                                y_next = y_reg + YEAR_W'(1);
                                if (ymod_reg == YMOD_TOP)
                                begin
                                    ymod_next = '0;
                                    cent_next = cent_reg + CENT_W'(1);
                                end
                                else
                                begin
                                    ymod_next = ymod_reg + YMOD_W'(1);
                                end
                            end
                        end
                        else
                        begin
                            m_next = m_reg + MONTH_W'(1);
                        end
                    end
                end
                else
                begin
                    if (bwd_sum > $signed(REM_W'(0)))
                    begin
                        d_next     = bwd_sum[DAY_W-1:0];
                        r_next     = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Step back to the last day of the previous month.
                        r_next = bwd_sum;
                        if (m_reg == JAN)
                        begin
                            if (y_reg == '0)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                m_next = DEC;
                                d_next = month_len(DEC, 1'b0);
                                y_next = y_reg - YEAR_W'(1);
                                if (ymod_reg == '0)
                                begin
                                    ymod_next = YMOD_TOP;
                                    cent_next = cent_reg - CENT_W'(1);
                                end
                                else
                                begin
                                    ymod_next = ymod_reg - YMOD_W'(1);
                                end
                            end
                        end
                        else
                        begin
                            m_next = m_reg - MONTH_W'(1);
                            d_next = month_len(m_reg - MONTH_W'(1), leap);
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid           = (state_reg == S_DONE);
    assign rsp.out_month       = err_reg ? sm_reg : m_reg;
    assign rsp.out_day         = err_reg ? sd_reg : d_reg;
    assign rsp.out_year        = err_reg ? sy_reg : y_reg;
    assign rsp.input_corrected = corr_reg;
    assign rsp.range_error     = err_reg;

endmodule
